FILE: src/chcs_pkg.sv
// shared types and constants of the color histogram cosine similarity core
package chcs_pkg;

   // histogram geometry
   localparam int CHCS_BIN_COUNT  = 1000;
   localparam int CHCS_BIN_W      = $clog2(CHCS_BIN_COUNT);
   localparam int CHCS_COUNT_BITS = 20;

   // input beat field widths
   localparam int CHCS_ACTION_W = 2;
   localparam int CHCS_COLOR_W  = 8;

   // result beat field widths, similarity is Q1.16 up to and including 1.0
   localparam int CHCS_FRAC_BITS = 16;
   localparam int CHCS_SIM_W     = CHCS_FRAC_BITS + 1;
   localparam int CHCS_STEP_W    = $clog2(CHCS_SIM_W);

   // bin mapping: bin = 9 * (100 r + 10 g + b) / 255
   localparam int CHCS_KEY_W      = 18;
   localparam int CHCS_RED_MULT   = 100;
   localparam int CHCS_GREEN_MULT = 10;
   localparam int CHCS_SCALE_MULT = 9;
   localparam int CHCS_DIVISOR    = 255;
   // reciprocal of 255 scaled by 2^23, rounded up, so the estimate is never low
   localparam int CHCS_RECIP      = 32897;
   localparam int CHCS_RECIP_SH   = 23;
   localparam int CHCS_RECIP_W    = 16;
   localparam int CHCS_EST_W      = CHCS_KEY_W + CHCS_RECIP_W - CHCS_RECIP_SH;

   // request actions
   typedef enum logic [CHCS_ACTION_W-1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_ADD     = 2'd1,
      ACT_COMPARE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // multiplier status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

FILE: src/chcs_if.sv
// request and response channel interfaces
interface chcs_req_if;
   import chcs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CHCS_ACTION_W-1:0] action;
   logic                    set_select;
   logic [CHCS_COLOR_W-1:0]  red;
   logic [CHCS_COLOR_W-1:0]  green;
   logic [CHCS_COLOR_W-1:0]  blue;

   modport source (output valid, action, set_select, red, green, blue, input ready);
   modport sink   (input valid, action, set_select, red, green, blue, output ready);
endinterface

interface chcs_rsp_if;
   import chcs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHCS_SIM_W-1:0] similarity;
   logic                  valid_res;

   modport source (output valid, similarity, valid_res, input ready);
   modport sink   (input valid, similarity, valid_res, output ready);
endinterface

FILE: src/color_histogram_cosine_similarity_core.sv
// top level: two color histograms with running sums and a cosine similarity unit
//
//   channel   dir   beat contents                                  handshake
//   req_chan  in    action, set_select, red, green, blue           valid / ready
//   rsp_chan  out   similarity, valid_res (compare only)           valid / ready
//
// clear visits every bin (1000) with ready low; an add walks the bin estimate, fix, read
// and update states; a compare with both histograms nonempty runs the shared shift-add
// multiplier (two products) and then the root search, one result bit per SQA and SQB
// pass, before the result beat
// reset starts the same clearing pass of both bin memories
// a finished result waits in the response register; a new request is taken meanwhile
module color_histogram_cosine_similarity_core #(
   parameter int COUNT_BITS = chcs_pkg::CHCS_COUNT_BITS
) (
   input  logic      clock,
   input  logic      reset,
   chcs_req_if.sink  req_chan,
   chcs_rsp_if.source rsp_chan
);
   import chcs_pkg::*;

   localparam int SUM_W  = 2 * COUNT_BITS + CHCS_BIN_W;
   localparam int PROD_W = 2 * SUM_W;
   localparam int WIDE_W = PROD_W + 2 * CHCS_FRAC_BITS + 4;

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_BINEST = 13'b0000000000100,
      ST_BINFIX = 13'b0000000001000,
      ST_READ   = 13'b0000000010000,
      ST_UPDATE = 13'b0000000100000,
      ST_PGO    = 13'b0000001000000,
      ST_PWAIT  = 13'b0000010000000,
      ST_RGO    = 13'b0000100000000,
      ST_RWAIT  = 13'b0001000000000,
      ST_SQA    = 13'b0010000000000,
      ST_SQB    = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CHCS_BIN_W-1:0] clr_addr_ff, clr_addr_in;
   logic [CHCS_KEY_W-1:0] key_ff, key_in;
   logic [CHCS_EST_W-1:0] est_ff, est_in;
   logic [CHCS_BIN_W-1:0] bin_ff, bin_in;
   logic                  sel_ff, sel_in;

   logic [COUNT_BITS-1:0] mem_a [CHCS_BIN_COUNT];
   logic [COUNT_BITS-1:0] mem_b [CHCS_BIN_COUNT];
   logic [COUNT_BITS-1:0] rd_a_ff, rd_b_ff;

   logic [SUM_W-1:0] dot_ff, dot_in;
   logic [SUM_W-1:0] norm_a_ff, norm_a_in;
   logic [SUM_W-1:0] norm_b_ff, norm_b_in;

   logic [WIDE_W-1:0] rhs_ff, rhs_in;
   logic [WIDE_W-1:0] p2k_ff, p2k_in;
   logic [WIDE_W-1:0] sq_ff, sq_in;
   logic [WIDE_W-1:0] cross_ff, cross_in;
   logic [WIDE_W-1:0] part_ff, part_in;
   logic [WIDE_W-1:0] cand;
   logic [WIDE_W-1:0] cross_upd;
   logic [CHCS_STEP_W-1:0] step_ff, step_in;
   logic [CHCS_SIM_W-1:0]  q_ff, q_in;
   logic                   nonempty_ff, nonempty_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHCS_SIM_W-1:0] rsp_sim_ff, rsp_sim_in;
   logic                  rsp_vres_ff, rsp_vres_in;
   logic                  rsp_load;

   logic                  req_fire;
   logic [CHCS_KEY_W-1:0] key_sum;
   logic [CHCS_KEY_W+CHCS_RECIP_W-1:0] est_prod;
   logic [CHCS_EST_W+CHCS_COLOR_W-1:0] est_back;
   logic [COUNT_BITS-1:0] own_cnt, other_cnt;
   logic                  own_full;
   logic                  we_a, we_b;
   logic [CHCS_BIN_W-1:0] wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   logic                  mul_start;
   logic [SUM_W-1:0]      mul_a, mul_b;
   logic [PROD_W-1:0]     mul_prod;
   mul_status_type        mul_stat;

   // shared multiplier for the two wide products of a compare
   chcs_mul #(.OP_W(SUM_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_prod),
      .status  (mul_stat)
   );

   assign mul_start = (state_ff == ST_PGO) || (state_ff == ST_RGO);
   assign mul_a     = (state_ff == ST_RGO) ? dot_ff : norm_a_ff;
   assign mul_b     = (state_ff == ST_RGO) ? dot_ff : norm_b_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // bin key and reciprocal estimate
   assign key_sum  = CHCS_KEY_W'(req_chan.red) * CHCS_KEY_W'(CHCS_RED_MULT)
                   + CHCS_KEY_W'(req_chan.green) * CHCS_KEY_W'(CHCS_GREEN_MULT)
                   + CHCS_KEY_W'(req_chan.blue);
   assign est_prod = (CHCS_KEY_W+CHCS_RECIP_W)'(key_ff)
                   * (CHCS_KEY_W+CHCS_RECIP_W)'(CHCS_RECIP);
   assign est_back = (CHCS_EST_W+CHCS_COLOR_W)'(est_ff)
                   * (CHCS_EST_W+CHCS_COLOR_W)'(CHCS_DIVISOR);

   // counter update operands
   assign own_cnt   = sel_ff ? rd_b_ff : rd_a_ff;
   assign other_cnt = sel_ff ? rd_a_ff : rd_b_ff;
   assign own_full  = (own_cnt == {COUNT_BITS{1'b1}});

   // root search candidate and cross term
   assign cand      = part_ff + p2k_ff;
   assign cross_upd = cross_ff + (p2k_ff << 1);

   // response register load
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      key_in      = key_ff;
      est_in      = est_ff;
      bin_in      = bin_ff;
      sel_in      = sel_ff;
      dot_in      = dot_ff;
      norm_a_in   = norm_a_ff;
      norm_b_in   = norm_b_ff;
      rhs_in      = rhs_ff;
      p2k_in      = p2k_ff;
      sq_in       = sq_ff;
      cross_in    = cross_ff;
      part_in     = part_ff;
      step_in     = step_ff;
      q_in        = q_ff;
      nonempty_in = nonempty_ff;
      case (state_ff)
         ST_CLEAR: begin
            dot_in      = '0;
            norm_a_in   = '0;
            norm_b_in   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CHCS_BIN_W'(CHCS_BIN_COUNT - 1)) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               key_in = CHCS_KEY_W'(key_sum * CHCS_KEY_W'(CHCS_SCALE_MULT));
               sel_in = req_chan.set_select;
               case (action_type'(req_chan.action))
                  ACT_CLEAR:   state_in = ST_CLEAR;
                  ACT_ADD:     state_in = ST_BINEST;
                  ACT_COMPARE: begin
                     nonempty_in = (norm_a_ff != '0) && (norm_b_ff != '0);
                     q_in        = '0;
                     state_in    = ((norm_a_ff != '0) && (norm_b_ff != '0)) ? ST_PGO
                                                                            : ST_DONE;
                  end
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_BINEST: begin
            est_in   = CHCS_EST_W'(est_prod >> CHCS_RECIP_SH);
            state_in = ST_BINFIX;
         end
         ST_BINFIX: begin
            // the estimate is high by at most one
            if (est_back > (CHCS_EST_W+CHCS_COLOR_W)'(key_ff)) begin
               bin_in = CHCS_BIN_W'(est_ff - 1'b1);
            end else begin
               bin_in = CHCS_BIN_W'(est_ff);
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!own_full) begin
               dot_in = dot_ff + SUM_W'(other_cnt);
               if (sel_ff) begin
                  norm_b_in = norm_b_ff + SUM_W'({own_cnt, 1'b1});
               end else begin
                  norm_a_in = norm_a_ff + SUM_W'({own_cnt, 1'b1});
               end
            end
            state_in = ST_IDLE;
         end
         ST_PGO: begin
            state_in = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (mul_stat.done) begin
               p2k_in   = WIDE_W'(mul_prod) << (2 * CHCS_FRAC_BITS);
               state_in = ST_RGO;
            end
         end
         ST_RGO: begin
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (mul_stat.done) begin
               rhs_in   = WIDE_W'(mul_prod) << (2 * CHCS_FRAC_BITS);
               sq_in    = '0;
               cross_in = '0;
               step_in  = CHCS_STEP_W'(CHCS_FRAC_BITS);
               state_in = ST_SQA;
            end
         end
         ST_SQA: begin
            part_in  = sq_ff + cross_ff;
            state_in = ST_SQB;
         end
         ST_SQB: begin
            // try setting the current result bit
            if (cand <= rhs_ff) begin
               sq_in    = cand;
               cross_in = cross_upd >> 1;
               q_in     = q_ff | (CHCS_SIM_W'(1) << step_ff);
            end else begin
               cross_in = cross_ff >> 1;
            end
            p2k_in = p2k_ff >> 2;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in  = step_ff - 1'b1;
               state_in = ST_SQA;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sim_in   = rsp_sim_ff;
      rsp_vres_in  = rsp_vres_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_sim_in   = nonempty_ff ? q_ff : '0;
         rsp_vres_in  = nonempty_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      est_ff      <= est_in;
      bin_ff      <= bin_in;
      sel_ff      <= sel_in;
      dot_ff      <= dot_in;
      norm_a_ff   <= norm_a_in;
      norm_b_ff   <= norm_b_in;
      rhs_ff      <= rhs_in;
      p2k_ff      <= p2k_in;
      sq_ff       <= sq_in;
      cross_ff    <= cross_in;
      part_ff     <= part_in;
      step_ff     <= step_in;
      q_ff        <= q_in;
      nonempty_ff <= nonempty_in;
      rsp_sim_ff  <= rsp_sim_in;
      rsp_vres_ff <= rsp_vres_in;
   end

   // bin memory write port
   assign we_a    = (state_ff == ST_CLEAR) || ((state_ff == ST_UPDATE) && !sel_ff && !own_full);
   assign we_b    = (state_ff == ST_CLEAR) || ((state_ff == ST_UPDATE) && sel_ff && !own_full);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : bin_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : own_cnt + 1'b1;

   // histogram a
   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[bin_ff];
   end

   // histogram b
   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_b_ff <= mem_b[bin_ff];
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.similarity = rsp_sim_ff;
   assign rsp_chan.valid_res  = rsp_vres_ff;

endmodule

FILE: src/chcs_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module chcs_mul #(
   parameter int OP_W = 2 * chcs_pkg::CHCS_COUNT_BITS + chcs_pkg::CHCS_BIN_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [OP_W-1:0]         op_a,
   input  logic [OP_W-1:0]         op_b,
   output logic [2*OP_W-1:0]       product,
   output chcs_pkg::mul_status_type status
);
   import chcs_pkg::*;

   localparam int CNT_W = $clog2(OP_W + 1);

   logic [2*OP_W-1:0] acc_ff, acc_in;
   logic [2*OP_W-1:0] mcand_ff, mcand_in;
   logic [OP_W-1:0]   mplier_ff, mplier_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // one partial product per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = {{OP_W{1'b0}}, op_a};
         mplier_in = op_b;
         cnt_in    = CNT_W'(OP_W);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: src/chcs_checker.sv
// port-level checks for the similarity core, bound to the top level
module chcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [chcs_pkg::CHCS_ACTION_W-1:0] req_action,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [chcs_pkg::CHCS_SIM_W-1:0] rsp_similarity,
   input logic                            rsp_valid_res
);
   import chcs_pkg::*;

   // reset starts the clearing pass
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready right after reset");

   // a clear beat starts the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_CLEAR) |=> !req_ready)
      else $error("request ready right after a clear beat");

   // empty result carries a zero similarity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_similarity == '0))
      else $error("nonzero similarity on an empty result");

   // similarity never above one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_similarity <= CHCS_SIM_W'(1 << CHCS_FRAC_BITS)))
      else $error("similarity above 1.0");

   // a stalled response beat stays
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response beat dropped while stalled");

endmodule

bind color_histogram_cosine_similarity_core chcs_checker u_chcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_action     (req_chan.action),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_similarity (rsp_chan.similarity),
   .rsp_valid_res  (rsp_chan.valid_res)
);

FILE: dv/tb_color_histogram_cosine_similarity_core.sv
// self-checking testbench for the color histogram cosine similarity core
`timescale 1ns / 100ps

module tb_color_histogram_cosine_similarity_core;
   import chcs_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [CHCS_SIM_W-1:0] similarity;
      logic                  valid_res;
   } cosine_type;

   logic clock;
   logic reset;

   chcs_req_if req_chan();
   chcs_rsp_if rsp_chan();

   color_histogram_cosine_similarity_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // histogram mirror and running sums
   logic [CHCS_COUNT_BITS-1:0] count_a [CHCS_BIN_COUNT];
   logic [CHCS_COUNT_BITS-1:0] count_b [CHCS_BIN_COUNT];
   logic [63:0] dot_acc;
   logic [63:0] sq_a_acc;
   logic [63:0] sq_b_acc;

   cosine_type cosine_q[$];
   int  fail_count;
   bit  gaps_on;
   int  quiet_cycles;
   int  n_add, n_compare, n_clear, n_none, n_results;

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // no beat for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic empty_histograms();
      for (int i = 0; i < CHCS_BIN_COUNT; i++) begin
         count_a[i] = '0;
         count_b[i] = '0;
      end
      dot_acc  = '0;
      sq_a_acc = '0;
      sq_b_acc = '0;
   endtask

   // largest q with q*q*|A|^2*|B|^2 <= (65536*dot)^2
   function automatic cosine_type cosine_q16();
      cosine_type  res;
      logic [191:0] norm_prod, rhs, lhs;
      logic [31:0] lo, hi, mid;
      res = '0;
      if (sq_a_acc == 0 || sq_b_acc == 0) return res;
      norm_prod = 192'(sq_a_acc) * 192'(sq_b_acc);
      rhs = (192'(dot_acc) * 192'(dot_acc)) << 32;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         lhs = 192'(mid) * 192'(mid) * norm_prod;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      res.similarity = lo[CHCS_SIM_W-1:0];
      res.valid_res  = 1'b1;
      return res;
   endfunction

   // update the mirror for one accepted beat
   task automatic predict_beat(action_type act, logic sel, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b);
      int unsigned bin;
      logic [CHCS_COUNT_BITS-1:0] own, other;
      case (act)
         ACT_CLEAR: begin
            empty_histograms();
            n_clear++;
         end
         ACT_ADD: begin
            n_add++;
            bin = (9 * (100 * r + 10 * g + b)) / 255;
            own   = sel ? count_b[bin] : count_a[bin];
            other = sel ? count_a[bin] : count_b[bin];
            // saturated bin leaves everything alone
            if (own != '1) begin
               if (sel) begin
                  count_b[bin] = own + 1'b1;
                  sq_b_acc += 2 * 64'(own) + 1;
               end else begin
                  count_a[bin] = own + 1'b1;
                  sq_a_acc += 2 * 64'(own) + 1;
               end
               dot_acc += 64'(other);
            end
         end
         ACT_COMPARE: begin
            n_compare++;
            cosine_q.insert(cosine_q.size(), cosine_q16());
         end
         default: n_none++;
      endcase
   endtask

   // send one beat, with an optional random gap before it
   task automatic send_beat(action_type act, logic sel, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.set_select <= sel;
      req_chan.red        <= r;
      req_chan.green      <= g;
      req_chan.blue       <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_beat(act, sel, r, g, b);
   endtask

   // stop sending and wait for every expected result
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (cosine_q.size() != 0) @(posedge clock);
   endtask

   // response checker with random backpressure
   initial begin
      int stall;
      cosine_type want;
      rsp_chan.ready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_results++;
            if (cosine_q.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               want = cosine_q.pop_front();
               if (rsp_chan.similarity !== want.similarity) begin
                  $error("similarity: expected %0d, got %0d", want.similarity,
                         rsp_chan.similarity);
                  fail_count++;
               end
               if (rsp_chan.valid_res !== want.valid_res) begin
                  $error("valid_res: expected %0d, got %0d", want.valid_res,
                         rsp_chan.valid_res);
                  fail_count++;
               end
            end
         end
         // random stall bursts, started only while gaps are on
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(0, 2);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // empty histograms, then one side only
   task automatic test_empty();
      send_beat(ACT_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
      send_beat(ACT_ADD, 1'b0, 8'd0, 8'd0, 8'd0);
      send_beat(ACT_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
      send_beat(ACT_CLEAR, 1'b0, 8'd0, 8'd0, 8'd0);
      send_beat(ACT_ADD, 1'b1, 8'd255, 8'd255, 8'd255);
      send_beat(ACT_COMPARE, 1'b1, 8'd255, 8'd255, 8'd255);
   endtask

   // one side only, then shared bins with unequal counts, then an extra bin on each side
   task automatic test_extremes();
      send_beat(ACT_ADD, 1'b0, 8'd255, 8'd255, 8'd255);
      send_beat(ACT_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
      send_beat(ACT_ADD, 1'b0, 8'd255, 8'd255, 8'd255);
      send_beat(ACT_ADD, 1'b1, 8'd255, 8'd255, 8'd255);
      send_beat(ACT_ADD, 1'b0, 8'd0, 8'd255, 8'd0);
      send_beat(ACT_ADD, 1'b1, 8'd0, 8'd255, 8'd0);
      send_beat(ACT_COMPARE, 1'b1, 8'd0, 8'd0, 8'd0);
      send_beat(ACT_ADD, 1'b1, 8'd0, 8'd0, 8'd255);
      send_beat(ACT_ADD, 1'b0, 8'd128, 8'd1, 8'd127);
      send_beat(ACT_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
   endtask

   // unused action changes nothing
   task automatic test_unused_action();
      send_beat(ACT_NONE, 1'b1, 8'd255, 8'd0, 8'd255);
      send_beat(ACT_NONE, 1'b0, 8'd0, 8'd255, 8'd0);
      send_beat(ACT_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
      send_beat(ACT_CLEAR, 1'b1, 8'd255, 8'd255, 8'd255);
      send_beat(ACT_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
   endtask

   // mostly adds from a small palette so bins overlap, with compares sprinkled in
   task automatic test_random(int beats);
      logic [7:0] palette [8];
      int pick;
      for (int i = 0; i < 8; i++) palette[i] = 8'($urandom);
      for (int i = 0; i < beats; i++) begin
         if (i == beats / 2) wait_drained();
         if (i == beats - beats / 5) gaps_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 1)
            send_beat(ACT_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         else if (pick < 4)
            send_beat(ACT_NONE, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         else if (pick < 14)
            send_beat(ACT_COMPARE, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         else if (pick < 60)
            send_beat(ACT_ADD, 1'($urandom), palette[$urandom_range(0, 7)],
                      palette[$urandom_range(0, 7)], palette[$urandom_range(0, 7)]);
         else
            send_beat(ACT_ADD, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // main sequence
   initial begin
      fail_count = 0;
      gaps_on    = 1'b1;
      n_add = 0; n_compare = 0; n_clear = 0; n_none = 0; n_results = 0;
      empty_histograms();
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.action      <= ACT_NONE;
      req_chan.set_select  <= 1'b0;
      req_chan.red         <= '0;
      req_chan.green       <= '0;
      req_chan.blue        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty();
      test_extremes();
      test_unused_action();
      test_random(880);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d adds, %0d compares, %0d clears, %0d unused actions",
               n_add, n_compare, n_clear, n_none);
      $display("checked %0d similarity results with random gaps and stalls", n_results);
      if (fail_count == 0 && cosine_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
